/* hw/rtl/modular_exponentiation_defines.svh */
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MEXP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MEXP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mexp_pkg.sv */
// Package with widths, types and the sequencer states of the modular exponentiation block.
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int BASE_W    = 63;
    localparam int EXP_W     = 63;
    localparam int MOD_W     = 31;
    localparam int IN_DATA_W = 160;
    localparam int OUT_DATA_W = 32;
    localparam int CNT_W     = 6;
    localparam int SCAN_W    = BASE_W;
    localparam int PAD_W     = SCAN_W - MOD_W;

    localparam logic [CNT_W-1:0] REDUCE_LAST = CNT_W'(BASE_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST    = CNT_W'(MOD_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_SQR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              start;
        logic [SCAN_W-1:0] scan;
        logic [CNT_W-1:0]  last_cnt;
        logic [MOD_W-1:0]  addend;
        logic [MOD_W-1:0]  modulus;
    } unit_cmd_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [MOD_W-1:0] result;
    } unit_sts_t;

endpackage

/* hw/rtl/modular_exponentiation.sv */
// Runs a base reduction, then multiplications and squarings on the shared unit, then hands the result out.
// One squaring for each exponent bit below the top set bit, one multiplication per set bit.
// An exponent or modulus of zero skips the arithmetic and goes straight to the result.
// One request at a time, limited by the single shift, add and reduce unit.
// Reset is asynchronous and active low; it clears the sequencer and the output valid.
`timescale 1ns / 1ps

module modular_exponentiation (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0 up: base_value[62:0], exponent[62:0], modulus[30:0], zero pad.
    input  logic [mexp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0 up: power_result[30:0], zero pad.
    output logic [mexp_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import mexp_pkg::*;

    unit_cmd_t         cmd;
    unit_sts_t         sts;
    logic              res_valid;
    logic              res_ack;
    logic [MOD_W-1:0]  res_value;

    logic              out_valid_reg, out_valid_next;
    logic [MOD_W-1:0]  out_data_reg, out_data_next;

    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_base   (s_axis_tdata[BASE_W-1:0]),
        .in_exp    (s_axis_tdata[BASE_W+EXP_W-1:BASE_W]),
        .in_mod    (s_axis_tdata[BASE_W+EXP_W+MOD_W-1:BASE_W+EXP_W]),
        .cmd       (cmd),
        .sts       (sts),
        .res_valid (res_valid),
        .res_ack   (res_ack),
        .res_value (res_value)
    );

    mexp_mulred u_mulred (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts)
    );

    always_comb
    begin
        res_ack        = res_valid && (!out_valid_reg || m_axis_tready);
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_ack)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_value;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - MOD_W){1'b0}}, out_data_reg};

endmodule

/* hw/rtl/mexp_mulred.sv */
// Shared shift, add and reduce unit that handles one scan bit per cycle.
`timescale 1ns / 1ps

module mexp_mulred (
    input  logic                clk,
    input  logic                rst_n,
    input  mexp_pkg::unit_cmd_t cmd,
    output mexp_pkg::unit_sts_t sts
);
    import mexp_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [MOD_W-1:0]  r_reg, r_next;
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MOD_W-1:0]  addend_reg, addend_next;
    logic [MOD_W-1:0]  mod_reg, mod_next;

    logic [MOD_W:0]    dbl;
    logic [MOD_W:0]    dbl_red;
    logic [MOD_W:0]    sum;
    logic [MOD_W:0]    sum_red;

    always_comb
    begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, mod_reg}) ? (dbl - {1'b0, mod_reg}) : dbl;
        sum     = {1'b0, dbl_red[MOD_W-1:0]}
                  + (scan_reg[SCAN_W-1] ? {1'b0, addend_reg} : '0);
        sum_red = (sum >= {1'b0, mod_reg}) ? (sum - {1'b0, mod_reg}) : sum;

        busy_next   = busy_reg;
        done_next   = 1'b0;
        r_next      = r_reg;
        scan_next   = scan_reg;
        cnt_next    = cnt_reg;
        addend_next = addend_reg;
        mod_next    = mod_reg;

        if (cmd.start)
        begin
            busy_next   = 1'b1;
            r_next      = '0;
            scan_next   = cmd.scan;
            cnt_next    = cmd.last_cnt;
            addend_next = cmd.addend;
            mod_next    = cmd.modulus;
        end
        else if (busy_reg)
        begin
            r_next    = sum_red[MOD_W-1:0];
            scan_next = {scan_reg[SCAN_W-2:0], 1'b0};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        scan_reg   <= scan_next;
        cnt_reg    <= cnt_next;
        addend_reg <= addend_next;
        mod_reg    <= mod_next;
    end

    assign sts.busy   = busy_reg;
    assign sts.done   = done_reg;
    assign sts.result = r_reg;

endmodule

/* hw/rtl/mexp_ctrl.sv */
// Sequencer that runs base reduction, multiplications and squarings on the shared unit.
`timescale 1ns / 1ps
`include "modular_exponentiation_defines.svh"

module mexp_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mexp_pkg::BASE_W-1:0]  in_base,
    input  logic [mexp_pkg::EXP_W-1:0]   in_exp,
    input  logic [mexp_pkg::MOD_W-1:0]   in_mod,
    output mexp_pkg::unit_cmd_t          cmd,
    input  mexp_pkg::unit_sts_t          sts,
    output logic                         res_valid,
    input  logic                         res_ack,
    output logic [mexp_pkg::MOD_W-1:0]   res_value
);
    import mexp_pkg::*;

    state_t            state_reg, state_next;
    logic [MOD_W-1:0]  acc_reg, acc_next;
    logic [MOD_W-1:0]  sq_reg, sq_next;
    logic [EXP_W-1:0]  exp_reg, exp_next;
    logic [MOD_W-1:0]  mod_reg, mod_next;
    logic [MOD_W-1:0]  res_reg, res_next;

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        exp_next   = exp_reg;
        mod_next   = mod_reg;
        res_next   = res_reg;

        in_ready     = 1'b0;
        res_valid    = 1'b0;
        cmd.start    = 1'b0;
        cmd.scan     = '0;
        cmd.last_cnt = MUL_LAST;
        cmd.addend   = '0;
        cmd.modulus  = mod_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mod_next = in_mod;
                    exp_next = in_exp;
                    acc_next = MOD_W'(1);
                    if (in_exp == '0)
                    begin
                        res_next   = MOD_W'(1);
                        state_next = ST_FINISH;
                    end
                    else if (in_mod == '0)
                    begin
                        res_next   = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.start    = 1'b1;
                        cmd.scan     = in_base;
                        cmd.last_cnt = REDUCE_LAST;
                        cmd.addend   = MOD_W'(1);
                        cmd.modulus  = in_mod;
                        state_next   = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (sts.done)
                begin
                    sq_next    = sts.result;
                    cmd.start  = 1'b1;
                    cmd.addend = sts.result;
                    if (exp_reg[0])
                    begin
                        cmd.scan   = {acc_reg, {PAD_W{1'b0}}};
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        cmd.scan   = {sts.result, {PAD_W{1'b0}}};
                        state_next = ST_SQR;
                    end
                end
            end
            ST_MUL:
            begin
                if (sts.done)
                begin
                    acc_next = sts.result;
                    if (exp_reg[EXP_W-1:1] == '0)
                    begin
                        res_next   = sts.result;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        cmd.scan   = {sq_reg, {PAD_W{1'b0}}};
                        cmd.addend = sq_reg;
                        state_next = ST_SQR;
                    end
                end
            end
            ST_SQR:
            begin
                if (sts.done)
                begin
                    sq_next    = sts.result;
                    exp_next   = {1'b0, exp_reg[EXP_W-1:1]};
                    cmd.start  = 1'b1;
                    cmd.addend = sts.result;
                    if (exp_reg[1])
                    begin
                        cmd.scan   = {acc_reg, {PAD_W{1'b0}}};
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        cmd.scan   = {sts.result, {PAD_W{1'b0}}};
                        state_next = ST_SQR;
                    end
                end
            end
            ST_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        exp_reg <= exp_next;
        mod_reg <= mod_next;
        res_reg <= res_next;
    end

    assign res_value = res_reg;

    // The unit only runs while the sequencer waits on it.
    `MEXP_ASSERT_IMP(a_busy_in_op, clk, rst_n, sts.busy,
        (state_reg == ST_REDUCE) || (state_reg == ST_MUL) || (state_reg == ST_SQR),
        "Shared unit busy outside an arithmetic state.")

    // The running square stays reduced while it is an operand.
    `MEXP_ASSERT_IMP(a_sq_reduced, clk, rst_n,
        (state_reg == ST_MUL) || (state_reg == ST_SQR), sq_reg < mod_reg,
        "Running square is not below the modulus.")

    // A finished exponentiation leaves the unit idle.
    `MEXP_ASSERT_NXT(a_finish_idle, clk, rst_n,
        (state_reg != ST_FINISH) && (state_next == ST_FINISH), !sts.busy,
        "Result raised while the shared unit is still running.")

endmodule
